// ===== rtl/ordered_list_insert_erase_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shorthand for the concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_ERASE_TOP_DEFINES_SVH
`define ORDERED_LIST_INSERT_ERASE_TOP_DEFINES_SVH

// expression holds at every edge out of reset
`define OLIE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds at the same edge as the antecedent
`define OLIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds at the edge after the antecedent
`define OLIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/olie_pkg.sv =====
// ----------------------------------------------------------------------------
// olie_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package olie_pkg;

  localparam int KIND_W       = 3;
  localparam int POS_W        = 7;
  localparam int DATA_W       = 64;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_READ   = 3'd4,
    KIND_WRITE  = 3'd5,
    KIND_CLEAR  = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
  } flags_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    shift_up;
    logic    at_end;
    logic    shift_down;
    logic    write_one;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    rd_stage1;
    logic    rd_stage2;
    logic    out_load;
    status_t status;
  } cmd_t;

endpackage

// ===== rtl/olie_ctrl.sv =====
// ----------------------------------------------------------------------------
// olie_ctrl
// Request sequencer: decodes the kind, checks bounds, steps reads through the
// datapath mux tree and hands results to the output register.
// ----------------------------------------------------------------------------
module olie_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [olie_pkg::KIND_W-1:0]        in_kind,
  output logic                               in_stall,
  output logic                               out_valid,
  input  logic                               out_stall,
  input  olie_pkg::flags_t                   flags,
  output olie_pkg::cmd_t                     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_PUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   read_go;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // request decode, acts at the accept edge
  always_comb begin
    cmd        = '0;
    cmd.status = olie_pkg::ST_OK;
    read_go    = 1'b0;
    cmd.accept = accept;
    if (accept) begin
      unique case (olie_pkg::kind_t'(in_kind))
        olie_pkg::KIND_PUSH: begin
          if (flags.full) begin
            cmd.status = olie_pkg::ST_FULL;
          end else begin
            cmd.shift_up = 1'b1;
            cmd.at_end   = 1'b1;
            cmd.cnt_inc  = 1'b1;
          end
        end
        olie_pkg::KIND_POP: begin
          if (flags.empty) begin
            cmd.status = olie_pkg::ST_EMPTY;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
        end
        olie_pkg::KIND_INSERT: begin
          if (flags.pos_gt_cnt) begin
            cmd.status = olie_pkg::ST_RANGE;
          end else if (flags.full) begin
            cmd.status = olie_pkg::ST_FULL;
          end else begin
            cmd.shift_up = 1'b1;
            cmd.cnt_inc  = 1'b1;
          end
        end
        olie_pkg::KIND_ERASE: begin
          if (flags.pos_ge_cnt) begin
            cmd.status = olie_pkg::ST_RANGE;
          end else begin
            cmd.shift_down = 1'b1;
            cmd.cnt_dec    = 1'b1;
          end
        end
        olie_pkg::KIND_READ: begin
          if (flags.pos_ge_cnt) begin
            cmd.status = olie_pkg::ST_RANGE;
          end else begin
            read_go = 1'b1;
          end
        end
        olie_pkg::KIND_WRITE: begin
          if (flags.pos_ge_cnt) begin
            cmd.status = olie_pkg::ST_RANGE;
          end else begin
            cmd.write_one = 1'b1;
          end
        end
        olie_pkg::KIND_CLEAR: begin
          cmd.cnt_clr = 1'b1;
        end
        default: begin
          // unused kind: no effect, status ok
        end
      endcase
    end
    cmd.rd_stage1 = (state_r == S_RD1);
    cmd.rd_stage2 = (state_r == S_RD2);
    cmd.out_load  = (state_r == S_PUT) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = read_go ? S_RD1 : S_PUT;
        end
      end
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_PUT;
      S_PUT: begin
        if (cmd.out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/olie_dp.sv =====
// ----------------------------------------------------------------------------
// olie_dp
// Row of entry cells with shift up/down, entry count, two-stage
// registered read mux and the result/output registers.
// ----------------------------------------------------------------------------
module olie_dp #(
  parameter int CAPACITY = olie_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [olie_pkg::POS_W-1:0]         in_position,
  input  logic [olie_pkg::DATA_W-1:0]        in_value,
  input  olie_pkg::cmd_t                     cmd,
  output olie_pkg::flags_t                   flags,
  output logic [olie_pkg::STATUS_W-1:0]      out_status,
  output logic [olie_pkg::DATA_W-1:0]        out_read_data,
  output logic [olie_pkg::POS_W-1:0]         out_count_after
);

  localparam int POS_W  = olie_pkg::POS_W;
  localparam int DATA_W = olie_pkg::DATA_W;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  // read mux: groups of up to eight cells, then one select across groups
  localparam int LO_W   = (IDX_W < 3) ? IDX_W : 3;
  localparam int GS     = 1 << LO_W;
  localparam int NGRP   = (CAPACITY + GS - 1) / GS;

  logic [DATA_W-1:0]   cells_r [CAPACITY];
  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    pos_r;
  logic [DATA_W-1:0]   grp_r   [NGRP];
  logic [DATA_W-1:0]   grp_nxt [NGRP];
  logic [DATA_W-1:0]   grp_sel;
  logic [DATA_W-1:0]   rd_r;
  olie_pkg::status_t   status_r;
  logic [olie_pkg::STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_rd_r;
  logic [POS_W-1:0]    out_cnt_r;
  logic [CMP_W-1:0]    cnt_e;
  logic [CMP_W-1:0]    pos_e;
  logic [CMP_W-1:0]    ep;

  assign cnt_e = CMP_W'(count_r);
  assign pos_e = CMP_W'(in_position);
  // push is an insert at the current end
  assign ep    = cmd.at_end ? cnt_e : pos_e;

  assign flags.full       = (count_r == CNT_W'(CAPACITY));
  assign flags.empty      = (count_r == '0);
  assign flags.pos_gt_cnt = (pos_e > cnt_e);
  assign flags.pos_ge_cnt = (pos_e >= cnt_e);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IE = CMP_W'(i);
    logic [DATA_W-1:0] below;
    logic [DATA_W-1:0] above;
    if (i == 0) begin : g_first
      assign below = cells_r[i];
    end else begin : g_rest
      assign below = cells_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above = cells_r[i];
    end else begin : g_mid
      assign above = cells_r[i+1];
    end
    always_ff @(posedge clk) begin
      if (cmd.shift_up) begin
        if (IE == ep) begin
          cells_r[i] <= in_value;
        end else if (IE > ep) begin
          cells_r[i] <= below;
        end
      end else if (cmd.shift_down) begin
        if (IE >= ep) begin
          cells_r[i] <= above;
        end
      end else if (cmd.write_one) begin
        if (IE == ep) begin
          cells_r[i] <= in_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_clr) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  // first read stage: one cell per group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GS; j++) begin
        if ((g * GS + j < CAPACITY) && (pos_r[LO_W-1:0] == LO_W'(j))) begin
          grp_nxt[g] = cells_r[g * GS + j];
        end
      end
    end
  end

  if (NGRP == 1) begin : g_one_grp
    assign grp_sel = grp_r[0];
  end else begin : g_many_grp
    assign grp_sel = grp_r[pos_r[IDX_W-1:LO_W]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_r    <= IDX_W'(in_position);
      rd_r     <= '0;
      status_r <= cmd.status;
    end else if (cmd.rd_stage2) begin
      rd_r <= grp_sel;
    end
    if (cmd.rd_stage1) begin
      grp_r <= grp_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_rd_r     <= rd_r;
      out_cnt_r    <= POS_W'(count_r);
    end
  end

  assign out_status      = out_status_r;
  assign out_read_data   = out_rd_r;
  assign out_count_after = out_cnt_r;

endmodule

// ===== rtl/ordered_list_insert_erase_top.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_top
// Fixed-capacity ordered list of 64-bit words with push, pop, insert, erase,
// read, write and clear requests; one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Push, pop, insert, erase, write, clear and
// every failed request go from S_IDLE straight to S_PUT, where the result is
// loaded into the output register unless that register is stalled. A
// successful read first passes through S_RD1 and S_RD2, the registered
// two-level mux that picks the word out of the entry row. Insert and erase
// shift all later entries at the accepting edge. A new request is accepted
// once the previous result sits in the output register, even while that
// result is still stalled; its own result then waits for as long as the
// output register stays stalled. Entry contents are not reset; only the entry
// count is.
`include "ordered_list_insert_erase_top_defines.svh"

module ordered_list_insert_erase_top #(
  parameter int CAPACITY = olie_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [olie_pkg::KIND_W-1:0]        in_kind,
  input  logic [olie_pkg::POS_W-1:0]         in_position,
  input  logic [olie_pkg::DATA_W-1:0]        in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [olie_pkg::STATUS_W-1:0]      out_status,
  output logic [olie_pkg::DATA_W-1:0]        out_read_data,
  output logic [olie_pkg::POS_W-1:0]         out_count_after
);

  localparam int POS_W = olie_pkg::POS_W;
  localparam logic [POS_W-1:0] CAP_MASK = POS_W'(CAPACITY);

  olie_pkg::cmd_t   cmd;
  olie_pkg::flags_t flags;

  olie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  olie_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_position     (in_position),
    .in_value        (in_value),
    .cmd             (cmd),
    .flags           (flags),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_count_after (out_count_after)
  );

  `OLIE_ASSERT_ALWAYS(a_one_update, $onehot0({cmd.shift_up, cmd.shift_down, cmd.write_one}), "more than one entry update at once")
  `OLIE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second request taken while one is in flight")
  `OLIE_ASSERT_IMP(a_full_count, out_valid && (out_status == olie_pkg::ST_FULL), out_count_after == CAP_MASK, "full reported below capacity")
  `OLIE_ASSERT_IMP(a_empty_count, out_valid && (out_status == olie_pkg::ST_EMPTY), out_count_after == '0, "empty reported with entries")

endmodule
